### rtl/assert_macros.svh
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/frfc_pkg.sv
// Package for the fragment reassembly frame cache: constants and codes.
// No dependencies.
package frfc_pkg;
  localparam int CACHE_DEPTH_DEF = 8;
  localparam int BITMAP_BITS = 32;
  localparam logic [1:0] ACT_FRAG  = 2'd0;
  localparam logic [1:0] ACT_WHOLE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;
  localparam logic [1:0] REG_FSZ   = 2'd0;
  localparam logic [1:0] REG_CAP   = 2'd1;
  localparam logic [1:0] REG_PRE   = 2'd2;
  localparam logic [15:0] FSZ_RESET = 16'd1400;
  localparam logic [23:0] CAP_RESET = 24'd1048576;
  localparam logic [3:0]  PRE_RESET = 4'd3;
endpackage

### rtl/frfc_div.sv
// Restoring divider, one quotient bit per cycle, ceiling of 24b by 16b.
// Depends on nothing but itself.
module frfc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quot_sat
);
  logic [23:0] q;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic [24:0] qc;

  assign trial = {rem[15:0], q[23]};
  assign qc = {1'b0, q} + {24'd0, (rem != 17'd0)};
  assign quot_sat = (qc > 25'd65535) ? 16'hFFFF : qc[15:0];

  // One shift-subtract step a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= dividend;
        rem  <= '0;
        dvs  <= (divisor == 16'd0) ? 16'd1 : divisor;
        cnt  <= 5'd24;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          q   <= {q[22:0], 1'b1};
        end else begin
          rem <= trial;
          q   <= {q[22:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/frfc_ring.sv
// Descriptor ring memory: length and sequence per slot, one write and one
// registered read port. Depends on frfc_pkg for nothing but sizing by parameter.
module frfc_ring #(
  parameter int CACHE_DEPTH = frfc_pkg::CACHE_DEPTH_DEF,
  localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [39:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [39:0]   rdata
);
  logic [39:0] mem [CACHE_DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/fragment_reassembly_frame_cache_unit.sv
// Top level of the fragment reassembly frame cache.
// Depends on frfc_pkg, frfc_div, frfc_ring.
//
//  channel | signals                         | direction
//  in      | in_valid/in_ready + 6 fields    | input
//  out     | out_valid/out_ready + 12 fields | output
//  cfg     | cfg_we, cfg_index, cfg_data     | input
//
// One transaction at a time. After an accept, a first fragment passes S_DIV
// (24-step divider), S_FRAG, S_OUT; a read S_RDWAIT, S_READ (registered
// ring memory read), S_OUT; other fragments and whole frames S_FRAG, S_OUT;
// a no-op S_OUT. The result waits in an output register; a new transaction
// is taken once it is delivered. Synchronous reset, no clearing pass.
module fragment_reassembly_frame_cache_unit #(
  parameter int CACHE_DEPTH = frfc_pkg::CACHE_DEPTH_DEF,
  localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1,
  localparam int CW = $clog2(CACHE_DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] seqnum,
  input  logic        first_flag,
  input  logic [23:0] frame_bytes,
  input  logic [15:0] frag_pos,
  input  logic [15:0] payload_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic [23:0] store_offset,
  output logic        frame_done,
  output logic [2:0]  done_slot,
  output logic [23:0] done_size,
  output logic        read_valid,
  output logic [2:0]  read_slot,
  output logic [23:0] read_size,
  output logic [15:0] read_seq,
  output logic        prefilling,
  output logic [31:0] dropped_total,
  output logic [31:0] received_total
);
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_FRAG, S_RDWAIT, S_READ, S_OUT} state_t;
  state_t state;

  // configuration
  logic [15:0] fsz_reg;
  logic [23:0] cap_reg;
  logic [3:0]  pre_reg;
  always_ff @(posedge clk) begin
    if (rst) begin
      fsz_reg <= frfc_pkg::FSZ_RESET;
      cap_reg <= frfc_pkg::CAP_RESET;
      pre_reg <= frfc_pkg::PRE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        frfc_pkg::REG_FSZ: fsz_reg <= cfg_data[15:0];
        frfc_pkg::REG_CAP: cap_reg <= cfg_data;
        frfc_pkg::REG_PRE: pre_reg <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // captured transaction
  logic [1:0]  act;
  logic [15:0] seq_q, idx_q, plen_q;

  // divider, started at the accept edge with the incoming frame size
  logic        div_start, div_done;
  logic [15:0] div_q;
  frfc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(frame_bytes),
    .divisor(fsz_reg), .done(div_done), .quot_sat(div_q)
  );

  // ring memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [39:0]   mem_wdata, mem_rdata;
  logic [AW-1:0] head_ptr, tail_ptr;
  frfc_ring #(.CACHE_DEPTH(CACHE_DEPTH)) u_ring (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(head_ptr), .rdata(mem_rdata)
  );

  // reassembly state
  logic        assembling;
  logic [15:0] current_seq, expected_frags, got_frags;
  logic [23:0] got_bytes;
  logic [31:0] seen_bitmap;
  logic [CACHE_DEPTH-1:0] slot_full;
  logic [CW-1:0] fill_count;
  logic        buffering_flag;
  logic [31:0] drop_counter, recv_counter;

  // offset product, registered at capture then used in S_FRAG
  logic [15:0] fsz_eff;
  logic [31:0] off_q;
  assign fsz_eff = (fsz_reg == 16'd0) ? 16'd1 : fsz_reg;

  // combinational evaluation of a fragment with current state
  logic        go, fit, in_map;
  logic [32:0] end_pos;
  logic [15:0] gf_new;
  logic [23:0] gb_new;
  logic        complete;
  assign in_map = idx_q < 16'(frfc_pkg::BITMAP_BITS);
  assign go = assembling && (current_seq == seq_q) &&
              !(in_map && seen_bitmap[idx_q[4:0]]);
  assign end_pos = {1'b0, off_q} + {17'd0, plen_q};
  assign fit = end_pos <= {9'd0, cap_reg};
  assign gf_new = fit ? got_frags + 16'd1 : got_frags;
  assign gb_new = fit ? got_bytes + {8'd0, plen_q} : got_bytes;
  assign complete = go && (gf_new == expected_frags);

  // cache insert evaluation
  logic        ins_req;
  logic [23:0] ins_len;
  logic        evict, ins_ok;
  logic [CW-1:0] fc_after_evict, fc_after;
  assign evict = fill_count >= CW'(CACHE_DEPTH);
  assign ins_ok = ins_len <= cap_reg;
  assign fc_after_evict = evict ? fill_count - CW'(1) : fill_count;
  assign fc_after = fc_after_evict + (ins_ok ? CW'(1) : CW'(0));

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(CACHE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    ins_req = 1'b0;
    ins_len = {8'd0, plen_q};
    if (state == S_FRAG && act == frfc_pkg::ACT_FRAG) begin
      ins_req = complete;
      ins_len = gb_new;
    end else if (state == S_FRAG && act == frfc_pkg::ACT_WHOLE) begin
      ins_req = 1'b1;
    end
  end

  assign mem_we    = ins_req && ins_ok;
  assign mem_waddr = tail_ptr;
  assign mem_wdata = {seq_q, ins_len};

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign div_start = (state == S_IDLE) && in_valid &&
                     action == frfc_pkg::ACT_FRAG && first_flag;

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      assembling <= 1'b0;
      current_seq <= '0;
      expected_frags <= '0;
      got_frags <= '0;
      got_bytes <= '0;
      seen_bitmap <= '0;
      slot_full <= '0;
      head_ptr <= '0;
      tail_ptr <= '0;
      fill_count <= '0;
      buffering_flag <= 1'b1;
      drop_counter <= '0;
      recv_counter <= '0;
      act <= frfc_pkg::ACT_NOP;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act <= action;
            seq_q <= seqnum;
            idx_q <= frag_pos;
            plen_q <= payload_len;
            off_q <= frag_pos * fsz_eff;
            accepted <= 1'b0;
            store_offset <= '0;
            frame_done <= 1'b0;
            done_slot <= '0;
            done_size <= '0;
            read_valid <= 1'b0;
            read_slot <= '0;
            read_size <= '0;
            read_seq <= '0;
            case (action)
              frfc_pkg::ACT_FRAG:  state <= first_flag ? S_DIV : S_FRAG;
              frfc_pkg::ACT_WHOLE: state <= S_FRAG;
              frfc_pkg::ACT_READ:  state <= S_RDWAIT;
              default:             state <= S_OUT;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (assembling && current_seq != seq_q) drop_counter <= drop_counter + 32'd1;
            current_seq <= seq_q;
            got_bytes <= '0;
            got_frags <= '0;
            seen_bitmap <= '0;
            expected_frags <= div_q;
            assembling <= 1'b1;
            state <= S_FRAG;
          end
        end
        S_FRAG: begin
          if (act == frfc_pkg::ACT_FRAG && go) begin
            if (fit) begin
              accepted <= 1'b1;
              store_offset <= off_q[23:0];
              got_bytes <= gb_new;
              got_frags <= gf_new;
              if (in_map) seen_bitmap[idx_q[4:0]] <= 1'b1;
            end
            if (complete) begin
              assembling <= 1'b0;
              recv_counter <= recv_counter + 32'd1;
            end
          end
          if (act == frfc_pkg::ACT_WHOLE) recv_counter <= recv_counter + 32'd1;
          if (ins_req) begin
            logic [CACHE_DEPTH-1:0] sf;
            sf = slot_full;
            if (evict) begin
              sf[head_ptr] = 1'b0;
              head_ptr <= ptr_inc(head_ptr);
              drop_counter <= drop_counter + 32'd1;
            end
            if (ins_ok) begin
              sf[tail_ptr] = 1'b1;
              tail_ptr <= ptr_inc(tail_ptr);
              frame_done <= 1'b1;
              done_slot <= 3'(tail_ptr);
              done_size <= ins_len;
              if (buffering_flag && {4'd0, fc_after} >= {{CW{1'b0}}, pre_reg})
                buffering_flag <= 1'b0;
            end
            slot_full <= sf;
            fill_count <= fc_after;
          end
          state <= S_OUT;
        end
        S_RDWAIT: state <= S_READ;
        S_READ: begin
          if (!buffering_flag && fill_count != '0 && slot_full[head_ptr]) begin
            read_valid <= 1'b1;
            read_slot <= 3'(head_ptr);
            read_size <= mem_rdata[23:0];
            read_seq <= mem_rdata[39:24];
            slot_full[head_ptr] <= 1'b0;
            head_ptr <= ptr_inc(head_ptr);
            fill_count <= fill_count - CW'(1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign prefilling = buffering_flag;
  assign dropped_total = drop_counter;
  assign received_total = recv_counter;
endmodule

### rtl/frfc_checker.sv
// Port-level checker for the frame cache, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module frfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        frame_done,
  input logic        read_valid,
  input logic        accepted,
  input logic [31:0] received_total
);
  `CHK_IMPL(a_excl, clk, rst, out_valid, !(read_valid && (frame_done || accepted)), "read mixed with insert")
  `CHK_IMPL(a_noin, clk, rst, out_valid, !in_ready, "input taken while result pending")
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `CHK_NEXT(a_recv, clk, rst, in_ready && !in_valid, $stable(received_total), "counter moved idle")
endmodule

bind fragment_reassembly_frame_cache_unit frfc_checker u_frfc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .frame_done(frame_done),
  .read_valid(read_valid), .accepted(accepted), .received_total(received_total)
);

### dv/fragment_reassembly_frame_cache_unit_tb.sv
// Testbench for fragment_reassembly_frame_cache_unit: directed and random transactions,
// checked against a behavioral predictor of reassembly, ring cache and counters.
// Depends on frfc_pkg and the RTL top level.
module fragment_reassembly_frame_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = frfc_pkg::CACHE_DEPTH_DEF;

  typedef struct packed {
    logic        accepted;
    logic [23:0] store_offset;
    logic        frame_done;
    logic [2:0]  done_slot;
    logic [23:0] done_size;
    logic        read_valid;
    logic [2:0]  read_slot;
    logic [23:0] read_size;
    logic [15:0] read_seq;
    logic        prefilling;
    logic [31:0] dropped_total;
    logic [31:0] received_total;
  } frame_status_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = frfc_pkg::REG_FSZ;
  logic [23:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  logic [1:0] action = frfc_pkg::ACT_NOP;
  logic [15:0] seqnum = '0;
  logic first_flag = 0;
  logic [23:0] frame_bytes = '0;
  logic [15:0] frag_pos = '0;
  logic [15:0] payload_len = '0;
  logic out_valid, out_ready = 0;
  logic accepted, frame_done, read_valid, prefilling;
  logic [23:0] store_offset, done_size, read_size;
  logic [2:0] done_slot, read_slot;
  logic [15:0] read_seq;
  logic [31:0] dropped_total, received_total;

  fragment_reassembly_frame_cache_unit i_dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // predictor state
  logic [15:0] frag_bytes;
  logic [23:0] cap_bytes;
  logic [3:0]  prefill_need;
  logic        asm_open;
  logic [15:0] asm_seq, asm_expected, asm_count;
  logic [23:0] asm_bytes;
  logic [31:0] dup_map;
  logic        ring_full [DEPTH];
  logic [23:0] ring_len [DEPTH];
  logic [15:0] ring_seq [DEPTH];
  logic [2:0]  ring_head, ring_tail;
  int          ring_count;
  logic        buffering;
  logic [31:0] drops, receives;

  frame_status_t status_q[$];
  int  fail_count = 0;
  bit  calm = 0;   // no idling in the last part

  function automatic void reset_model();
    frag_bytes = frfc_pkg::FSZ_RESET; cap_bytes = frfc_pkg::CAP_RESET;
    prefill_need = frfc_pkg::PRE_RESET;
    asm_open = 0; asm_seq = 0; asm_expected = 0; asm_count = 0;
    asm_bytes = 0; dup_map = 0;
    for (int i = 0; i < DEPTH; i++) ring_full[i] = 0;
    ring_head = 0; ring_tail = 0; ring_count = 0; buffering = 1;
    drops = 0; receives = 0;
  endfunction

  // ring insert with eviction; returns 1 when stored
  function automatic bit ring_put(logic [23:0] len, logic [15:0] sq, output logic [2:0] slot);
    slot = 0;
    if (ring_count >= DEPTH) begin
      ring_full[ring_head] = 0;
      ring_head++;
      ring_count--;
      drops++;
    end
    if (len > cap_bytes) return 0;
    slot = ring_tail;
    ring_len[ring_tail] = len; ring_seq[ring_tail] = sq; ring_full[ring_tail] = 1;
    ring_tail++;
    ring_count++;
    if (buffering && ring_count >= prefill_need) buffering = 0;
    return 1;
  endfunction

  function automatic frame_status_t predict_status(logic [1:0] act, logic [15:0] sq, logic fst,
      logic [23:0] tot, logic [15:0] idx, logic [15:0] plen);
    frame_status_t r;
    longint unsigned fsz, n, off;
    logic [2:0] slot;
    bit go;
    r = '0;
    fsz = (frag_bytes == 0) ? 1 : frag_bytes;
    if (act == frfc_pkg::ACT_FRAG) begin
      go = 1;
      if (fst) begin
        n = (longint'(tot) + fsz - 1) / fsz;
        if (asm_open && asm_seq != sq) drops++;
        asm_seq = sq; asm_bytes = 0; asm_count = 0; dup_map = 0;
        asm_expected = (n > 16'hFFFF) ? 16'hFFFF : n[15:0];
        asm_open = 1;
      end
      if (!asm_open || asm_seq != sq) go = 0;
      if (go && idx < 32 && dup_map[idx[4:0]]) go = 0;
      if (go) begin
        off = longint'(idx) * fsz;
        if (off + plen <= cap_bytes) begin
          r.accepted = 1;
          r.store_offset = off[23:0];
          asm_bytes = asm_bytes + plen;
          asm_count = asm_count + 1;
          if (idx < 32) dup_map[idx[4:0]] = 1;
        end
        if (asm_count == asm_expected) begin
          if (ring_put(asm_bytes, sq, slot)) begin
            r.frame_done = 1; r.done_slot = slot; r.done_size = asm_bytes;
          end
          asm_open = 0;
          receives++;
        end
      end
    end else if (act == frfc_pkg::ACT_WHOLE) begin
      if (ring_put({8'd0, plen}, sq, slot)) begin
        r.frame_done = 1; r.done_slot = slot; r.done_size = plen;
      end
      receives++;
    end else if (act == frfc_pkg::ACT_READ) begin
      if (!buffering && ring_count > 0 && ring_full[ring_head]) begin
        r.read_valid = 1; r.read_slot = ring_head;
        r.read_size = ring_len[ring_head]; r.read_seq = ring_seq[ring_head];
        ring_full[ring_head] = 0;
        ring_head++;
        ring_count--;
      end
    end
    r.prefilling = buffering;
    r.dropped_total = drops;
    r.received_total = receives;
    return r;
  endfunction

  // send one transaction, with an optional idle burst before it;
  // valid stays up after the accept until an idle burst or a drain drops it
  task automatic send_item(logic [1:0] act, logic [15:0] sq, logic fst, logic [23:0] tot,
      logic [15:0] idx, logic [15:0] plen);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    status_q.push_back(predict_status(act, sq, fst, tot, idx, plen));
    action <= act; seqnum <= sq; first_flag <= fst; frame_bytes <= tot;
    frag_pos <= idx; payload_len <= plen; in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // receiver stalls
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      frame_status_t e;
      if (status_q.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        e = status_q.pop_front();
        if (e.accepted !== accepted) begin
          $error("accepted exp %0h got %0h", e.accepted, accepted); fail_count++; end
        if (e.store_offset !== store_offset) begin
          $error("store_offset exp %0h got %0h", e.store_offset, store_offset); fail_count++; end
        if (e.frame_done !== frame_done) begin
          $error("frame_done exp %0h got %0h", e.frame_done, frame_done); fail_count++; end
        if (e.done_slot !== done_slot) begin
          $error("done_slot exp %0h got %0h", e.done_slot, done_slot); fail_count++; end
        if (e.done_size !== done_size) begin
          $error("done_size exp %0h got %0h", e.done_size, done_size); fail_count++; end
        if (e.read_valid !== read_valid) begin
          $error("read_valid exp %0h got %0h", e.read_valid, read_valid); fail_count++; end
        if (e.read_slot !== read_slot) begin
          $error("read_slot exp %0h got %0h", e.read_slot, read_slot); fail_count++; end
        if (e.read_size !== read_size) begin
          $error("read_size exp %0h got %0h", e.read_size, read_size); fail_count++; end
        if (e.read_seq !== read_seq) begin
          $error("read_seq exp %0h got %0h", e.read_seq, read_seq); fail_count++; end
        if (e.prefilling !== prefilling) begin
          $error("prefilling exp %0h got %0h", e.prefilling, prefilling); fail_count++; end
        if (e.dropped_total !== dropped_total) begin
          $error("dropped_total exp %0h got %0h", e.dropped_total, dropped_total);
          fail_count++; end
        if (e.received_total !== received_total) begin
          $error("received_total exp %0h got %0h", e.received_total, received_total);
          fail_count++; end
      end
    end
  end

  // drop valid, wait for all results, then a quiet gap
  task automatic drain();
    in_valid <= 0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    drain();
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == frfc_pkg::REG_FSZ) frag_bytes = val[15:0];
    else if (idx == frfc_pkg::REG_CAP) cap_bytes = val;
    else if (idx == frfc_pkg::REG_PRE) prefill_need = val[3:0];
  endtask

  // one well-formed frame, fragments in shuffled order with an occasional duplicate
  task automatic send_frame(logic [15:0] sq, int nfrag);
    int fsz, order[$];
    fsz = (frag_bytes == 0) ? 1 : frag_bytes;
    for (int i = 0; i < nfrag; i++) order.push_back(i);
    order.shuffle();
    for (int i = 0; i < nfrag; i++) begin
      send_item(frfc_pkg::ACT_FRAG, sq, i == 0, 24'(nfrag * fsz - $urandom_range(0, fsz - 1)),
                16'(order[i]), 16'($urandom_range(0, fsz)));
      if ($urandom_range(0, 7) == 0)
        send_item(frfc_pkg::ACT_FRAG, sq, 0, '0, 16'(order[i]), 16'($urandom));
    end
  endtask

  task automatic test_directed();
    send_item(frfc_pkg::ACT_READ, 0, 0, 0, 0, 0);                 // empty, prefilling
    send_item(frfc_pkg::ACT_FRAG, 16'h1234, 0, 0, 0, 10);         // stray, none open
    send_item(frfc_pkg::ACT_FRAG, 16'hFFFF, 1, 24'hFFFFFF, 16'hFFFF, 16'hFFFF); // over capacity
    send_item(frfc_pkg::ACT_FRAG, 16'hFFFF, 0, 0, 3, 100);
    send_item(frfc_pkg::ACT_FRAG, 16'hFFFF, 0, 0, 3, 100);        // duplicate
    send_item(frfc_pkg::ACT_FRAG, 16'h0001, 0, 0, 4, 100);        // wrong seq
    send_item(frfc_pkg::ACT_FRAG, 16'h0002, 1, 24'd2800, 0, 1400); // abandons open frame
    send_item(frfc_pkg::ACT_FRAG, 16'h0002, 0, 0, 1, 1400);
    send_item(frfc_pkg::ACT_FRAG, 16'h0003, 1, 24'd0, 0, 0);      // zero total, accepted
    send_item(frfc_pkg::ACT_FRAG, 16'h0003, 0, 0, 16'hFFFF, 16'hFFFF); // rejected, frame stays open
    send_item(frfc_pkg::ACT_WHOLE, 16'hAAAA, 1, 24'h555555, 16'hAAAA, 16'hFFFF);
    send_item(frfc_pkg::ACT_WHOLE, 16'h5555, 0, 0, 16'h5555, 0);
    send_item(frfc_pkg::ACT_READ, 0, 0, 0, 0, 0);
    send_item(frfc_pkg::ACT_NOP, 16'hFFFF, 1, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 9; i++)
      send_item(frfc_pkg::ACT_WHOLE, 16'(i), 0, 0, 0, 16'(i * 7)); // eviction
    send_item(frfc_pkg::ACT_READ, 0, 0, 0, 0, 0);
  endtask

  task automatic test_config_extremes();
    write_reg(frfc_pkg::REG_FSZ, 24'd0);                           // acts as one byte
    write_reg(frfc_pkg::REG_CAP, 24'd1);
    write_reg(frfc_pkg::REG_PRE, 24'd15);                          // above ring depth
    send_frame(16'h0100, 3);
    send_item(frfc_pkg::ACT_WHOLE, 16'h0101, 0, 0, 0, 16'd5);      // oversize
    send_item(frfc_pkg::ACT_READ, 0, 0, 0, 0, 0);
    write_reg(frfc_pkg::REG_FSZ, 24'hFFFF);
    write_reg(frfc_pkg::REG_CAP, 24'hFFFFFF);
    write_reg(frfc_pkg::REG_PRE, 24'd0);
    send_item(frfc_pkg::ACT_FRAG, 16'h0200, 1, 24'hFFFFFF, 0, 16'hFFFF);
    send_item(frfc_pkg::ACT_FRAG, 16'h0200, 0, 0, 16'd255, 16'hFFFF);
    send_item(frfc_pkg::ACT_WHOLE, 16'h0201, 0, 0, 0, 16'd9);
    send_item(frfc_pkg::ACT_READ, 0, 0, 0, 0, 0);
    // saturating fragment count
    write_reg(frfc_pkg::REG_FSZ, 24'd1);
    send_item(frfc_pkg::ACT_FRAG, 16'h0300, 1, 24'hFFFFFF, 16'd40, 16'd0);
  endtask

  // random mix, mostly well-formed frames
  task automatic test_random(int n_items, int fsz_val, int cap_val, int pre_val);
    int sent;
    write_reg(frfc_pkg::REG_FSZ, 24'(fsz_val));
    write_reg(frfc_pkg::REG_CAP, 24'(cap_val));
    write_reg(frfc_pkg::REG_PRE, 24'(pre_val));
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_frame(16'($urandom), $urandom_range(1, 5));
          sent += 4;
        end
        4, 5: begin
          send_item(frfc_pkg::ACT_WHOLE, 16'($urandom), 1'($urandom), 24'($urandom),
                    16'($urandom),
                    16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3000)));
          sent++;
        end
        6, 7: begin
          send_item(frfc_pkg::ACT_READ, 16'($urandom), 1'($urandom), 24'($urandom),
                    16'($urandom), 16'($urandom));
          sent++;
        end
        8: begin
          send_item(frfc_pkg::ACT_FRAG, 16'($urandom), 1'($urandom), 24'($urandom),
                    16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 40)),
                    16'($urandom));
          sent++;
        end
        default: begin
          send_item(frfc_pkg::ACT_NOP, 16'($urandom), 1'($urandom), 24'($urandom),
                    16'($urandom), 16'($urandom));
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random(200, 1400, 1048576, 3);
    test_random(150, 64, 300, 8);
    test_random(150, 1, 16777215, 1);
    calm = 1;
    test_random(150, 1000, 5000, 2);
    drain();
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #4ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
